>>> src/deq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    localparam int DEQ_DEPTH = 256;

    localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
    localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
    localparam logic [2:0] FUNC_CLEAR      = 3'd4;
    localparam logic [2:0] FUNC_QUERY      = 3'd5;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] push_value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] popped_value;
        logic [8:0]         entry_count;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic read;
        logic show;
    } cmd_t;

endpackage

`default_nettype wire

>>> src/deq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output deq_pkg::cmd_t    cmd,
    output logic             busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SHOW
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   exec_reg;
    logic   read_reg;
    logic   show_reg;
    logic   load;

    assign load = start && !busy_reg;

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:  state_next = load ? ST_EXEC : ST_IDLE;
            ST_EXEC:  state_next = ST_READ;
            ST_READ:  state_next = ST_SHOW;
            ST_SHOW:  state_next = load ? ST_EXEC : ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            exec_reg  <= 1'b0;
            read_reg  <= 1'b0;
            show_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next == ST_EXEC) || (state_next == ST_READ);
            exec_reg  <= (state_next == ST_EXEC);
            read_reg  <= (state_next == ST_READ);
            show_reg  <= (state_next == ST_SHOW);
        end
    end

    assign cmd.load = load;
    assign cmd.exec = exec_reg;
    assign cmd.read = read_reg;
    assign cmd.show = show_reg;
    assign busy     = busy_reg;

endmodule

`default_nettype wire

>>> src/deq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module deq_datapath #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire deq_pkg::cmd_t cmd,
    input  wire deq_pkg::req_t request,
    output deq_pkg::rsp_t      response
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [31:0]   mem [DEPTH];

    logic [2:0]    func_reg;
    logic [31:0]   value_reg;
    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [AW-1:0] tail_reg;
    logic [AW-1:0] tail_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [1:0]    status_reg;
    logic [1:0]    status_next;
    logic          pop_ok_reg;
    logic          pop_ok_next;
    logic [31:0]   rd_a_reg;
    logic [31:0]   rd_b_reg;
    logic [31:0]   popped_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] pop_addr;
    logic [AW-1:0] rd_a_addr;
    logic [AW-1:0] head_prev;
    logic [AW-1:0] head_succ;
    logic [AW-1:0] tail_prev;
    logic [AW-1:0] tail_succ;
    logic          is_empty;
    logic          is_full;
    logic [CW+8:0] count_ext;

    assign head_prev = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - 1'b1;
    assign head_succ = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_prev = (tail_reg == '0) ? AW'(DEPTH - 1) : tail_reg - 1'b1;
    assign tail_succ = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CW'(DEPTH));

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        status_next = deq_pkg::STATUS_OK;
        pop_ok_next = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = tail_reg;
        pop_addr    = head_reg;
        unique case (func_reg)
            deq_pkg::FUNC_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    status_next = deq_pkg::STATUS_FULL;
                end
                else
                begin
                    head_next  = head_prev;
                    count_next = count_reg + 1'b1;
                    wr_en      = 1'b1;
                    wr_addr    = head_prev;
                end
            end
            deq_pkg::FUNC_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status_next = deq_pkg::STATUS_FULL;
                end
                else
                begin
                    tail_next  = tail_succ;
                    count_next = count_reg + 1'b1;
                    wr_en      = 1'b1;
                    wr_addr    = tail_reg;
                end
            end
            deq_pkg::FUNC_POP_FRONT:
            begin
                if (is_empty)
                begin
                    status_next = deq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    head_next   = head_succ;
                    count_next  = count_reg - 1'b1;
                    pop_ok_next = 1'b1;
                    pop_addr    = head_reg;
                end
            end
            deq_pkg::FUNC_POP_BACK:
            begin
                if (is_empty)
                begin
                    status_next = deq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    tail_next   = tail_prev;
                    count_next  = count_reg - 1'b1;
                    pop_ok_next = 1'b1;
                    pop_addr    = tail_prev;
                end
            end
            deq_pkg::FUNC_CLEAR:
            begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
            end
            default:
            begin
                status_next = deq_pkg::STATUS_OK;
            end
        endcase
    end

    assign rd_a_addr = cmd.exec ? pop_addr : head_reg;

    // word store
    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[wr_addr] <= value_reg;
        end
        if (cmd.exec || cmd.read)
        begin
            rd_a_reg <= mem[rd_a_addr];
        end
        if (cmd.read)
        begin
            rd_b_reg <= mem[tail_prev];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= request.func;
            value_reg <= request.push_value;
        end
        if (cmd.read)
        begin
            popped_reg <= pop_ok_reg ? rd_a_reg : 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            status_reg <= deq_pkg::STATUS_OK;
            pop_ok_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            pop_ok_reg <= pop_ok_next;
        end
    end

    assign count_ext = {9'd0, count_reg};

    assign response.status       = status_reg;
    assign response.popped_value = popped_reg;
    assign response.entry_count  = count_ext[8:0];
    assign response.front_value  = is_empty ? 32'sd0 : rd_a_reg;
    assign response.back_value   = is_empty ? 32'sd0 : rd_b_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("count beyond depth");

    a_ring_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CW'(DEPTH)) |-> head_reg == tail_reg)
        else $error("head and tail disagree with count");

    a_hold_outside_exec: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.exec |=> $stable(count_reg) && $stable(head_reg) && $stable(tail_reg))
        else $error("queue state moved outside execute");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && status_next == deq_pkg::STATUS_FULL |=> $stable(count_reg))
        else $error("push to full queue changed count");

    a_pop_status: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && pop_ok_next |-> status_next == deq_pkg::STATUS_OK && !is_empty)
        else $error("pop on empty queue");

endmodule

`default_nettype wire

>>> src/double_ended_queue.sv
// double-ended queue of signed 32-bit words in a ring buffer of DEPTH entries
// input item: request (func, push_value), taken at a rising edge with start high
//   and busy low; func selects push front/back, pop front/back, clear or query
// result item: response (status, popped_value, entry_count, front_value,
//   back_value), valid for exactly one cycle while done is high
// every item gives exactly one result
// done is high in the show state, reached from the accepting edge via execute and read
// busy is high in execute and read and low again in the done cycle, so
//   the next item can be taken at the edge that ends it
// the controller states follow the access order of the word store:
//   execute (write or popped read), read front and back, present
// reset clears head, tail and count, leaving an empty queue; store contents
//   are not cleared; an entry's value reaches the response only after a push wrote it
// the receiver cannot stall: a result not taken in its done cycle is lost
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire deq_pkg::req_t request,
    output logic               busy,
    output logic               done,
    output deq_pkg::rsp_t      response
);

    deq_pkg::cmd_t cmd;

    deq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy)
    );

    deq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .request  (request),
        .response (response)
    );

    assign done = cmd.show;

endmodule

`default_nettype wire
